// File: src/svr_pkg.sv
`timescale 1ns / 1ps

package svr_pkg;

    localparam int SAMPLE_DEPTH = 8192;
    localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);
    localparam int LEN_W        = $clog2(SAMPLE_DEPTH + 1);

    localparam int ACTION_W     = 3;
    localparam int INDEX_W      = 13;
    localparam int SAMPLE_W     = 8;
    localparam int OUT_W        = 16;

    localparam int FREQ_W       = 18;
    localparam int RATE_W       = 18;
    localparam int SLEN_W       = 14;
    localparam int GAIN_W       = 9;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 18;

    localparam int PH_W         = 32;
    localparam int FRAC_W       = 16;
    localparam int IP_W         = PH_W - FRAC_W;
    localparam int CMP_W        = IP_W + 1;

    // shared restoring divider: step = (frequency << 16) / rate, wrap = ip % len
    localparam int DIV_N_W        = FREQ_W + FRAC_W;
    localparam int DIV_D_W        = RATE_W;
    localparam int DIV_CNT_W      = $clog2(DIV_N_W + 1);
    localparam int DIV_STEP_ITERS = DIV_N_W;
    localparam int DIV_WRAP_ITERS = IP_W;

    localparam logic [ACTION_W-1:0] ACT_LOAD    = ACTION_W'(0);
    localparam logic [ACTION_W-1:0] ACT_START   = ACTION_W'(1);
    localparam logic [ACTION_W-1:0] ACT_STOP    = ACTION_W'(2);
    localparam logic [ACTION_W-1:0] ACT_SET_POS = ACTION_W'(3);
    localparam logic [ACTION_W-1:0] ACT_FRAME   = ACTION_W'(4);

    localparam logic [CFG_IDX_W-1:0] CFG_FREQUENCY     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_RATE   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_LENGTH = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_LEFT     = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_RIGHT    = CFG_IDX_W'(4);

    typedef struct packed {
        logic store_wr;
        logic read_a;
        logic read_b;
        logic mix;
        logic emit;
        logic emit_zero;
        logic stop;
        logic set_pos;
        logic step_div;
        logic step_done;
        logic wrap_done;
    } svr_cmd_t;

    typedef struct packed {
        logic playing;
        logic wrap_needed;
        logic div_idle;
    } svr_status_t;

endpackage

// File: src/svr_if.sv
`timescale 1ns / 1ps

interface svr_req_if;
    import svr_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic [INDEX_W-1:0]         index;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       loop_request;

    modport source (output valid, output action, output index, output sample_value,
                    output loop_request, input ready);
    modport sink   (input valid, input action, input index, input sample_value,
                    input loop_request, output ready);
endinterface

interface svr_res_if;
    import svr_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] left_out;
    logic signed [OUT_W-1:0] right_out;
    logic                    still_playing;

    modport source (output valid, output left_out, output right_out,
                    output still_playing, input ready);
    modport sink   (input valid, input left_out, input right_out,
                    input still_playing, output ready);
endinterface

// File: src/sample_voice_resampler_unit.sv
`timescale 1ns / 1ps
// Single PCM voice with linear interpolation between neighboring samples.
// request channel: action, index, sample_value, loop_request. Loads write the
//   sample store, start arms the voice, stop halts it, set-position moves the playhead,
//   frame produces one item on the result channel (left_out, right_out,
//   still_playing). Other actions produce no result.
// cfg port: cfg_we/cfg_index/cfg_data write frequency, output_rate,
//   sample_length, gain_left, gain_right; write only while the voice is idle.
// Sequence: load, stop and set-position complete in the idle state. A frame while
//   playing reads the store twice on one read port, then does the interpolation
//   multiply and the gain multiply; a frame that runs past the end while looping
//   then takes the remainder in the shared restoring divider. Start issues the
//   step quotient to the same divider and writes it back when the divider is done.
// Reset: playhead and step cleared, voice stopped, registers at defaults. The
//   store is not cleared; only written entries are meaningful.
// Stall: the result register holds its item until taken. Non-frame items are
//   still accepted meanwhile; a frame waits in its last stage for the slot.
module sample_voice_resampler_unit
    import svr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    svr_req_if.sink               request,
    svr_res_if.source             result
);

    svr_cmd_t    cmd;
    svr_status_t status;

    svr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_action(request.action),
        .in_ready (request.ready),
        .out_valid(result.valid),
        .out_ready(result.ready),
        .status   (status),
        .cmd      (cmd)
    );

    svr_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .index        (request.index),
        .sample_value (request.sample_value),
        .loop_request (request.loop_request),
        .cmd          (cmd),
        .status       (status),
        .left_out     (result.left_out),
        .right_out    (result.right_out),
        .still_playing(result.still_playing)
    );

endmodule

// File: src/svr_ram.sv
`timescale 1ns / 1ps

module svr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/svr_div.sv
`timescale 1ns / 1ps

module svr_div
    import svr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_N_W-1:0]   dividend,
    input  logic [DIV_D_W-1:0]   divisor,
    input  logic [DIV_CNT_W-1:0] iters,
    output logic                 busy,
    output logic [DIV_N_W-1:0]   quotient,
    output logic [DIV_D_W-1:0]   remainder
);

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_N_W-1:0]   quo_reg, quo_next;
    logic [DIV_D_W-1:0]   rem_reg, rem_next;
    logic [DIV_D_W-1:0]   dvs_reg, dvs_next;
    logic [DIV_D_W:0]     shifted;
    logic [DIV_D_W:0]     diff;

    // one quotient bit per cycle, dividend shifts out of the top of quo_reg
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DIV_N_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = iters;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next = diff[DIV_D_W-1:0];
                quo_next = {quo_reg[DIV_N_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DIV_D_W-1:0];
                quo_next = {quo_reg[DIV_N_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: src/svr_ctrl.sv
`timescale 1ns / 1ps

module svr_ctrl
    import svr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [ACTION_W-1:0] in_action,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  svr_status_t         status,
    output svr_cmd_t            cmd
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_RD_B     = 7'b0000010,
        S_MIX      = 7'b0000100,
        S_GAIN     = 7'b0001000,
        S_ZERO     = 7'b0010000,
        S_DIV_STEP = 7'b0100000,
        S_WRAP     = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_action)
                        ACT_LOAD:    cmd.store_wr = 1'b1;
                        ACT_START:
                        begin
                            cmd.step_div = 1'b1;
                            state_next   = S_DIV_STEP;
                        end
                        ACT_STOP:    cmd.stop    = 1'b1;
                        ACT_SET_POS: cmd.set_pos = 1'b1;
                        ACT_FRAME:
                        begin
                            if (status.playing)
                            begin
                                cmd.read_a = 1'b1;
                                state_next = S_RD_B;
                            end
                            else
                            begin
                                state_next = S_ZERO;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RD_B:
            begin
                cmd.read_b = 1'b1;
                state_next = S_MIX;
            end
            S_MIX:
            begin
                cmd.mix    = 1'b1;
                state_next = S_GAIN;
            end
            S_GAIN:
            begin
                if (slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = status.wrap_needed ? S_WRAP : S_IDLE;
                end
            end
            S_ZERO:
            begin
                if (slot_free)
                begin
                    cmd.emit_zero = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_DIV_STEP:
            begin
                if (status.div_idle)
                begin
                    cmd.step_done = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_WRAP:
            begin
                if (status.div_idle)
                begin
                    cmd.wrap_done = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.emit || cmd.emit_zero)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: src/svr_dp.sv
`timescale 1ns / 1ps

module svr_dp
    import svr_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic [INDEX_W-1:0]         index,
    input  logic signed [SAMPLE_W-1:0] sample_value,
    input  logic                       loop_request,
    input  svr_cmd_t                   cmd,
    output svr_status_t                status,
    output logic signed [OUT_W-1:0]    left_out,
    output logic signed [OUT_W-1:0]    right_out,
    output logic                       still_playing
);

    logic [FREQ_W-1:0] freq_reg;
    logic [RATE_W-1:0] rate_reg;
    logic [SLEN_W-1:0] slen_reg;
    logic [GAIN_W-1:0] gain_l_reg;
    logic [GAIN_W-1:0] gain_r_reg;

    logic [PH_W-1:0] playhead_reg;
    logic [PH_W-1:0] step_reg;
    logic            playing_reg;
    logic            looping_reg;
    logic            loop_req_reg;

    logic                       a_zero_reg;
    logic                       b_zero_reg;
    logic signed [SAMPLE_W-1:0] a_reg;
    logic signed [OUT_W-1:0]    s_reg;
    logic [PH_W-1:0]            sum_reg;

    logic signed [OUT_W-1:0] left_reg;
    logic signed [OUT_W-1:0] right_reg;
    logic                    still_reg;

    logic [LEN_W-1:0]  eff_len;
    logic [CMP_W-1:0]  len_c;
    logic [CMP_W-1:0]  ip_a;
    logic [CMP_W-1:0]  ip_b;
    logic              a_oob;
    logic              b_oob;
    logic              end_hit;
    logic              wrap_loop;

    logic                ram_we;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [SAMPLE_W-1:0] ram_rdata;

    logic signed [SAMPLE_W-1:0] b_val;
    logic signed [SAMPLE_W:0]   diff;
    logic signed [25:0]         prod_i;
    logic signed [25:0]         acc;
    logic signed [25:0]         prod_l;
    logic signed [25:0]         prod_r;

    logic                 div_start;
    logic [DIV_N_W-1:0]   div_dividend;
    logic [DIV_D_W-1:0]   div_divisor;
    logic [DIV_CNT_W-1:0] div_iters;
    logic                 div_busy;
    logic [DIV_N_W-1:0]   div_quo;
    logic [DIV_D_W-1:0]   div_rem;

    function automatic logic signed [OUT_W-1:0] sat16(input logic signed [17:0] v);
        if (v > 18'sd32767)
        begin
            return 16'sh7FFF;
        end
        else if (v < -18'sd32768)
        begin
            return 16'sh8000;
        end
        else
        begin
            return v[OUT_W-1:0];
        end
    endfunction

    always_comb
    begin
        if (slen_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (32'(slen_reg) > SAMPLE_DEPTH)
        begin
            eff_len = LEN_W'(SAMPLE_DEPTH);
        end
        else
        begin
            eff_len = LEN_W'(slen_reg);
        end
    end

    assign len_c     = CMP_W'(eff_len);
    assign ip_a      = {1'b0, playhead_reg[PH_W-1:FRAC_W]};
    assign ip_b      = ip_a + CMP_W'(1);
    assign a_oob     = ip_a >= len_c;
    assign b_oob     = ip_b >= len_c;
    assign end_hit   = {1'b0, sum_reg[PH_W-1:FRAC_W]} >= len_c;
    assign wrap_loop = end_hit && looping_reg;

    // past the end: entry 0 when looping, forced zero otherwise
    assign ram_we = cmd.store_wr && (32'(index) < SAMPLE_DEPTH);
    assign ram_re = cmd.read_a || cmd.read_b;
    always_comb
    begin
        if (cmd.read_b)
        begin
            ram_raddr = b_oob ? '0 : ip_b[ADDR_W-1:0];
        end
        else
        begin
            ram_raddr = a_oob ? '0 : ip_a[ADDR_W-1:0];
        end
    end

    svr_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(SAMPLE_DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ADDR_W'(index)),
        .wdata(sample_value),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // a*(1-f) + b*f == a*2^16 + (b-a)*f
    assign b_val  = b_zero_reg ? '0 : $signed(ram_rdata);
    assign diff   = $signed({b_val[SAMPLE_W-1], b_val}) - $signed({a_reg[SAMPLE_W-1], a_reg});
    assign prod_i = diff * $signed({1'b0, playhead_reg[FRAC_W-1:0]});
    assign acc    = prod_i + $signed({{2{a_reg[SAMPLE_W-1]}}, a_reg, 16'h0000});
    assign prod_l = s_reg * $signed({1'b0, gain_l_reg});
    assign prod_r = s_reg * $signed({1'b0, gain_r_reg});

    assign div_start = cmd.step_div || (cmd.emit && wrap_loop);
    always_comb
    begin
        if (cmd.step_div)
        begin
            div_dividend = {freq_reg, {FRAC_W{1'b0}}};
            div_divisor  = (rate_reg == '0) ? DIV_D_W'(1) : DIV_D_W'(rate_reg);
            div_iters    = DIV_CNT_W'(DIV_STEP_ITERS);
        end
        else
        begin
            div_dividend = {sum_reg[PH_W-1:FRAC_W], {(DIV_N_W-IP_W){1'b0}}};
            div_divisor  = DIV_D_W'(eff_len);
            div_iters    = DIV_CNT_W'(DIV_WRAP_ITERS);
        end
    end

    svr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .iters    (div_iters),
        .busy     (div_busy),
        .quotient (div_quo),
        .remainder(div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg     <= FREQ_W'(22050);
            rate_reg     <= RATE_W'(44100);
            slen_reg     <= SLEN_W'(1);
            gain_l_reg   <= GAIN_W'(256);
            gain_r_reg   <= GAIN_W'(256);
            playhead_reg <= '0;
            step_reg     <= '0;
            playing_reg  <= 1'b0;
            looping_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FREQUENCY:     freq_reg   <= cfg_data[FREQ_W-1:0];
                    CFG_OUTPUT_RATE:   rate_reg   <= cfg_data[RATE_W-1:0];
                    CFG_SAMPLE_LENGTH: slen_reg   <= cfg_data[SLEN_W-1:0];
                    CFG_GAIN_LEFT:     gain_l_reg <= cfg_data[GAIN_W-1:0];
                    CFG_GAIN_RIGHT:    gain_r_reg <= cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.stop)
            begin
                playing_reg <= 1'b0;
            end
            if (cmd.set_pos)
            begin
                playhead_reg <= {{(IP_W-INDEX_W){1'b0}}, index, {FRAC_W{1'b0}}};
            end
            if (cmd.step_done)
            begin
                step_reg    <= (|div_quo[DIV_N_W-1:PH_W]) ? '1 : div_quo[PH_W-1:0];
                playing_reg <= 1'b1;
                looping_reg <= loop_req_reg;
            end
            if (cmd.emit)
            begin
                if (end_hit && !looping_reg)
                begin
                    playing_reg  <= 1'b0;
                    playhead_reg <= '0;
                end
                else if (!end_hit)
                begin
                    playhead_reg <= sum_reg;
                end
            end
            if (cmd.wrap_done)
            begin
                playhead_reg <= {div_rem[IP_W-1:0], sum_reg[FRAC_W-1:0]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step_div)
        begin
            loop_req_reg <= loop_request;
        end
        if (cmd.read_a)
        begin
            a_zero_reg <= a_oob && !looping_reg;
        end
        if (cmd.read_b)
        begin
            a_reg      <= a_zero_reg ? '0 : $signed(ram_rdata);
            b_zero_reg <= b_oob && !looping_reg;
        end
        if (cmd.mix)
        begin
            s_reg   <= acc[23:8];
            sum_reg <= playhead_reg + step_reg;
        end
        if (cmd.emit)
        begin
            left_reg  <= sat16(prod_l[25:8]);
            right_reg <= sat16(prod_r[25:8]);
            still_reg <= !(end_hit && !looping_reg);
        end
        else if (cmd.emit_zero)
        begin
            left_reg  <= '0;
            right_reg <= '0;
            still_reg <= 1'b0;
        end
    end

    assign status.playing     = playing_reg;
    assign status.wrap_needed = wrap_loop;
    assign status.div_idle    = !div_busy;

    assign left_out      = left_reg;
    assign right_out     = right_reg;
    assign still_playing = still_reg;

endmodule

// File: src/svr_checker.sv
`timescale 1ns / 1ps

module svr_checker
    import svr_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic [ACTION_W-1:0] req_action,
    input logic                res_valid,
    input logic                res_ready
);

    logic req_acc;
    assign req_acc = req_valid && req_ready;

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result item dropped while stalled");

    a_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc && req_action == ACT_FRAME |=> !req_ready)
        else $error("frame item did not occupy the voice");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc && req_action == ACT_START |=> !req_ready)
        else $error("start item did not run the step division");

    a_load_single: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc && (req_action == ACT_LOAD || req_action == ACT_STOP ||
                    req_action == ACT_SET_POS) |=> req_ready)
        else $error("single-cycle item stalled the request channel");

endmodule

bind sample_voice_resampler_unit svr_checker u_svr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .req_action(request.action),
    .res_valid (result.valid),
    .res_ready (result.ready)
);

// File: sim/sample_voice_resampler_unit_tb.sv
`timescale 1ns / 1ps

typedef struct packed {
    logic [svr_pkg::ACTION_W-1:0]        action;
    logic [svr_pkg::INDEX_W-1:0]         index;
    logic signed [svr_pkg::SAMPLE_W-1:0] sample_value;
    logic                                loop_request;
} voice_item_t;

typedef struct packed {
    logic signed [svr_pkg::OUT_W-1:0] left_out;
    logic signed [svr_pkg::OUT_W-1:0] right_out;
    logic                             still_playing;
} voice_frame_t;

typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_CYCLIC} rx_mode_t;

class voice_scoreboard;
    byte                         store [svr_pkg::SAMPLE_DEPTH];
    bit                          written [svr_pkg::SAMPLE_DEPTH];
    bit [svr_pkg::PH_W-1:0]      playhead;
    bit [svr_pkg::PH_W-1:0]      step_size;
    bit                          playing;
    bit                          looping;
    bit [svr_pkg::FREQ_W-1:0]    frequency;
    bit [svr_pkg::RATE_W-1:0]    output_rate;
    bit [svr_pkg::SLEN_W-1:0]    sample_length;
    bit [svr_pkg::GAIN_W-1:0]    gain_left;
    bit [svr_pkg::GAIN_W-1:0]    gain_right;
    voice_frame_t                frames_due [$];
    int                          mismatches;

    function new();
        playhead      = '0;
        step_size     = '0;
        playing       = 1'b0;
        looping       = 1'b0;
        frequency     = 22050;
        output_rate   = 44100;
        sample_length = 1;
        gain_left     = 256;
        gain_right    = 256;
        mismatches    = 0;
    endfunction

    function void write_reg(logic [svr_pkg::CFG_IDX_W-1:0] idx,
                            logic [svr_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            svr_pkg::CFG_FREQUENCY:     frequency     = data[svr_pkg::FREQ_W-1:0];
            svr_pkg::CFG_OUTPUT_RATE:   output_rate   = data[svr_pkg::RATE_W-1:0];
            svr_pkg::CFG_SAMPLE_LENGTH: sample_length = data[svr_pkg::SLEN_W-1:0];
            svr_pkg::CFG_GAIN_LEFT:     gain_left     = data[svr_pkg::GAIN_W-1:0];
            svr_pkg::CFG_GAIN_RIGHT:    gain_right    = data[svr_pkg::GAIN_W-1:0];
            default:                    ;
        endcase
    endfunction

    function int unsigned voice_len();
        if (sample_length == 0)
            return 1;
        if (sample_length > svr_pkg::SAMPLE_DEPTH)
            return svr_pkg::SAMPLE_DEPTH;
        return sample_length;
    endfunction

    function longint tap(int unsigned i, int unsigned len);
        if (i < len)
            return longint'(store[i]);
        return looping ? longint'(store[0]) : 0;
    endfunction

    function logic signed [svr_pkg::OUT_W-1:0] clip16(longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[svr_pkg::OUT_W-1:0];
    endfunction

    function void note_item(voice_item_t it);
        longint unsigned num;
        longint unsigned quo;
        longint unsigned div;
        int unsigned     len;
        int unsigned     ip;
        longint          a;
        longint          b;
        longint          fr;
        longint          s;
        voice_frame_t    fx;
        case (it.action)
            svr_pkg::ACT_LOAD:
            begin
                store[it.index]   = it.sample_value;
                written[it.index] = 1'b1;
            end
            svr_pkg::ACT_START:
            begin
                num = longint'(frequency) << svr_pkg::FRAC_W;
                div = (output_rate == 0) ? 1 : longint'(output_rate);
                quo = num / div;
                step_size = (quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
                playing = 1'b1;
                looping = it.loop_request;
            end
            svr_pkg::ACT_STOP:
                playing = 1'b0;
            svr_pkg::ACT_SET_POS:
                playhead = {3'b000, it.index, 16'h0000};
            svr_pkg::ACT_FRAME:
            begin
                if (!playing)
                begin
                    fx = '0;
                end
                else
                begin
                    len = voice_len();
                    ip  = playhead[31:16];
                    fr  = longint'(playhead[15:0]);
                    a   = tap(ip, len);
                    b   = tap(ip + 1, len);
                    s   = (a * (65536 - fr) + b * fr) >>> 8;
                    fx.left_out  = clip16((s * longint'(gain_left)) >>> 8);
                    fx.right_out = clip16((s * longint'(gain_right)) >>> 8);
                    playhead = playhead + step_size;
                    ip = playhead[31:16];
                    if (ip >= len)
                    begin
                        if (looping)
                            playhead = {16'(ip % len), playhead[15:0]};
                        else
                        begin
                            playing  = 1'b0;
                            playhead = '0;
                        end
                    end
                    fx.still_playing = playing;
                end
                frames_due.push_back(fx);
            end
            default:
                ;
        endcase
    endfunction

    function void check_frame(voice_frame_t got);
        voice_frame_t want;
        if (frames_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected frame: left %0d right %0d playing %0d",
                         got.left_out, got.right_out, got.still_playing);
            return;
        end
        want = frames_due.pop_front();
        if (got.left_out !== want.left_out || got.right_out !== want.right_out ||
            got.still_playing !== want.still_playing)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("frame mismatch: exp L %0d R %0d P %0d, got L %0d R %0d P %0d",
                         want.left_out, want.right_out, want.still_playing,
                         got.left_out, got.right_out, got.still_playing);
        end
    endfunction
endclass

module sample_voice_resampler_unit_tb;
    import svr_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 60;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 130;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    svr_req_if req_ch();
    svr_res_if res_ch();

    sample_voice_resampler_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .request   (req_ch),
        .result    (res_ch)
    );

    voice_scoreboard sb;
    int              burst_left;
    int              hold_request;
    int              cycle_count;
    bit              steady;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic voice_item_t make_item(logic [ACTION_W-1:0] act, int unsigned idx,
                                              int unsigned sval, bit lp);
        voice_item_t it;
        it.action       = act;
        it.index        = idx[INDEX_W-1:0];
        it.sample_value = sval[SAMPLE_W-1:0];
        it.loop_request = lp;
        return it;
    endfunction

    task automatic push_item(voice_item_t it);
        int gap;
        if (!steady && burst_left <= 0)
        begin
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 5);
            repeat (gap) @(negedge clk) req_ch.valid <= 1'b0;
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
                                                     : $urandom_range(1, 24);
        end
        @(negedge clk);
        req_ch.valid        <= 1'b1;
        req_ch.action       <= it.action;
        req_ch.index        <= it.index;
        req_ch.sample_value <= it.sample_value;
        req_ch.loop_request <= it.loop_request;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_item(it);
        burst_left--;
    endtask

    // frames never read a store entry that was never loaded
    task automatic issue(voice_item_t it);
        int unsigned len;
        int unsigned ip;
        int unsigned want [$];
        if (it.action == ACT_FRAME && sb.playing)
        begin
            len = sb.voice_len();
            ip  = sb.playhead[31:16];
            for (int k = 0; k < 2; k++)
            begin
                if (ip + k < len)
                    want.push_back(ip + k);
                else if (sb.looping)
                    want.push_back(0);
            end
            foreach (want[i])
                if (!sb.written[want[i]])
                    push_item(make_item(ACT_LOAD, want[i], $urandom_range(0, 255),
                                        1'($urandom_range(0, 1))));
        end
        push_item(it);
    endtask

    function automatic voice_item_t random_item(logic [ACTION_W-1:0] act);
        return make_item(act, $urandom_range(0, SAMPLE_DEPTH - 1), $urandom_range(0, 255),
                         1'($urandom_range(0, 1)));
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic load_settings(logic [CFG_DATA_W-1:0] f, logic [CFG_DATA_W-1:0] r,
                                 logic [CFG_DATA_W-1:0] len, logic [CFG_DATA_W-1:0] gl,
                                 logic [CFG_DATA_W-1:0] gr);
        write_reg(CFG_FREQUENCY, f);
        write_reg(CFG_OUTPUT_RATE, r);
        write_reg(CFG_SAMPLE_LENGTH, len);
        write_reg(CFG_GAIN_LEFT, gl);
        write_reg(CFG_GAIN_RIGHT, gr);
        @(negedge clk) cfg_we <= 1'b0;
    endtask

    task automatic drain_results();
        @(negedge clk) req_ch.valid <= 1'b0;
        burst_left = 0;
        while (sb.frames_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic directed_items();
        issue(make_item(ACT_FRAME, 0, 0, 0));
        issue(make_item(ACT_LOAD, 0, -128, 0));
        issue(make_item(ACT_LOAD, SAMPLE_DEPTH - 1, 127, 1));
        for (int a = ACT_FRAME + 1; a < (1 << ACTION_W); a++)
            issue(make_item(ACTION_W'(a), SAMPLE_DEPTH - 1, 255, 1));
        issue(make_item(ACT_START, 0, 0, 0));
        issue(make_item(ACT_FRAME, 0, 0, 0));
        issue(make_item(ACT_FRAME, 0, 0, 0));
        issue(make_item(ACT_FRAME, 0, 0, 0));
        issue(make_item(ACT_START, 0, 0, 1));
        issue(make_item(ACT_FRAME, 0, 0, 0));
        issue(make_item(ACT_FRAME, 0, 0, 0));
        issue(make_item(ACT_STOP, 0, 0, 0));
        issue(make_item(ACT_FRAME, 0, 0, 0));
        issue(make_item(ACT_SET_POS, SAMPLE_DEPTH - 1, 0, 0));
        issue(make_item(ACT_START, 0, 0, 1));
        issue(make_item(ACT_FRAME, 0, 0, 0));
        drain_results();
        // saturated step, zero rate, zero length
        load_settings(18'h3FFFF, 0, 0, 511, 0);
        issue(make_item(ACT_LOAD, 0, 127, 0));
        issue(make_item(ACT_START, 0, 0, 1));
        issue(make_item(ACT_FRAME, 0, 0, 0));
        issue(make_item(ACT_FRAME, 0, 0, 0));
        drain_results();
        load_settings(0, 18'h3FFFF, 14'h3FFF, 0, 511);
        issue(make_item(ACT_START, 0, 0, 0));
        issue(make_item(ACT_FRAME, 0, 0, 0));
        issue(make_item(ACT_SET_POS, 4000, 0, 0));
        issue(make_item(ACT_FRAME, 0, 0, 0));
        drain_results();
    endtask

    task automatic press_output();
        hold_request = 300;
        steady = 1'b1;
        issue(random_item(ACT_START));
        repeat (40) issue(random_item(ACT_FRAME));
        steady = 1'b0;
        drain_results();
    endtask

    task automatic run_phase(int p);
        logic [CFG_DATA_W-1:0] f;
        logic [CFG_DATA_W-1:0] r;
        logic [CFG_DATA_W-1:0] len_cfg;
        logic [CFG_DATA_W-1:0] gl;
        logic [CFG_DATA_W-1:0] gr;
        int unsigned           len;
        int                    pick;
        voice_item_t           it;
        f  = CFG_DATA_W'(($urandom_range(0, 5) == 0)
                         ? ($urandom_range(0, 1) ? 18'h3FFFF : 18'h0)
                         : $urandom_range(2000, 96000));
        pick = $urandom_range(0, 9);
        r  = CFG_DATA_W'((pick == 0) ? 18'h3FFFF : (pick == 1) ? 18'h0 : (pick == 2) ? 18'h1
                                     : $urandom_range(8000, 192000));
        pick = $urandom_range(0, 7);
        len_cfg = CFG_DATA_W'((pick == 0) ? ($urandom_range(0, 1) ? 18'h3FFF : 18'h0)
                : (pick == 1) ? $urandom_range(65, SAMPLE_DEPTH) : $urandom_range(1, 48));
        gl = CFG_DATA_W'(($urandom_range(0, 5) == 0)
                         ? ($urandom_range(0, 1) ? 18'h1FF : 18'h0)
                         : $urandom_range(0, 256));
        gr = CFG_DATA_W'(($urandom_range(0, 5) == 0)
                         ? ($urandom_range(0, 1) ? 18'h1FF : 18'h0)
                         : $urandom_range(0, 256));
        load_settings(f, r, len_cfg, gl, gr);
        len = sb.voice_len();
        for (int i = 0; i < ((len < 16) ? len : 16); i++)
            issue(make_item(ACT_LOAD, i, $urandom_range(0, 255), 1'($urandom_range(0, 1))));
        issue(random_item(ACT_START));
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            if (p == 3 && n == PHASE_ITEMS / 2)
                press_output();
            pick = $urandom_range(0, 99);
            it = random_item(ACT_FRAME);
            if (pick < 58)
                it.action = ACT_FRAME;
            else if (pick < 70)
            begin
                it.action = ACT_LOAD;
                if ($urandom_range(0, 1))
                    it.index = INDEX_W'($urandom_range(0, len - 1));
            end
            else if (pick < 77)
                it.action = ACT_START;
            else if (pick < 81)
                it.action = ACT_STOP;
            else if (pick < 89)
            begin
                it.action = ACT_SET_POS;
                if ($urandom_range(0, 9) < 7)
                    it.index = INDEX_W'($urandom_range(0, len - 1));
            end
            else if (pick < 94)
                it.action = ACTION_W'($urandom_range(ACT_FRAME + 1, (1 << ACTION_W) - 1));
            issue(it);
        end
        drain_results();
    endtask

    initial
    begin
        sb                  = new();
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        req_ch.valid        = 1'b0;
        req_ch.action       = '0;
        req_ch.index        = '0;
        req_ch.sample_value = '0;
        req_ch.loop_request = 1'b0;
        burst_left          = 0;
        hold_request        = 0;
        steady              = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;
        directed_items();
        for (int p = 0; p < PHASES; p++)
            run_phase(p);
        if (sb.mismatches == 0 && sb.frames_due.size() == 0)
            $display("sample_voice_resampler_unit test passed");
        else
            $display("sample_voice_resampler_unit test failed");
        $finish;
    end

    initial
    begin
        rx_mode_t mode;
        int       mode_left;
        int       hold_left;
        int       tick;
        res_ch.ready = 1'b0;
        mode         = RX_OPEN;
        mode_left    = 0;
        hold_left    = 0;
        tick         = 0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (mode_left == 0)
            begin
                mode      = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    RX_OPEN:  res_ch.ready <= 1'b1;
                    RX_LIGHT: res_ch.ready <= ($urandom_range(0, 3) != 0);
                    RX_HEAVY: res_ch.ready <= ($urandom_range(0, 9) < 3);
                    default:  res_ch.ready <= ((tick % 7) < 4);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            sb.check_frame(voice_frame_t'{left_out: res_ch.left_out,
                                          right_out: res_ch.right_out,
                                          still_playing: res_ch.still_playing});
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("sample_voice_resampler_unit test failed");
        $finish;
    end

endmodule

// File: sim.f
src/svr_pkg.sv
src/svr_if.sv
src/svr_ram.sv
src/svr_div.sv
src/svr_ctrl.sv
src/svr_dp.sv
src/sample_voice_resampler_unit.sv
src/svr_checker.sv
sim/sample_voice_resampler_unit_tb.sv
